>>> hw/rtl/svl_pkg.sv
// ---------------------------------------------------------------------------
// svl_pkg: shared types and constants
// Request and response payloads, operation and status codes, and the
// command that the sequencer hands to the row of list cells.
// ---------------------------------------------------------------------------
`default_nettype none

package svl_pkg;

    // most results that one dump request produces
    localparam int MAX_RESULTS = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_CLEAR  = 2'd3
    } svl_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } svl_status_t;

    // what every cell does in the coming cycle
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ROTATE = 2'd3
    } svl_cmd_t;

    typedef struct packed {
        svl_op_t            opcode;
        logic signed [31:0] operand;
    } svl_req_t;

    typedef struct packed {
        svl_status_t        status;
        logic signed [31:0] entry_value;
        logic               last_of_run;
        logic [4:0]         occupancy;
    } svl_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/svl_cell.sv
// ---------------------------------------------------------------------------
// svl_cell: one slot of the sorted list
// Holds one entry, compares it against the request operand and takes its next
// value from itself, the operand, a neighbor or the head cell as commanded.
// ---------------------------------------------------------------------------
`default_nettype none

module svl_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire svl_pkg::svl_cmd_t     cmd,
    input  wire logic [DATA_WIDTH-1:0] operand,
    input  wire logic                  used,
    input  wire logic                  tail,
    input  wire logic                  left_lt,
    input  wire logic [DATA_WIDTH-1:0] left_value,
    input  wire logic [DATA_WIDTH-1:0] right_value,
    input  wire logic [DATA_WIDTH-1:0] head_value,
    input  wire logic                  seen_in,
    output logic [DATA_WIDTH-1:0]      value,
    output logic                       lt,
    output logic                       seen_out
);
    import svl_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  eq;

    // compare against the operand
    assign lt       = used && ($signed(value_reg) < $signed(operand));
    assign eq       = used && (value_reg == operand);
    assign seen_out = seen_in || eq;
    assign value    = value_reg;

    // next entry value
    always_comb
    begin
        value_next = value_reg;
        case (cmd)
            CMD_INSERT:
            begin
                if (!lt)
                begin
                    value_next = left_lt ? operand : left_value;
                end
            end
            CMD_REMOVE:
            begin
                if (seen_out)
                begin
                    value_next = right_value;
                end
            end
            CMD_ROTATE:
            begin
                value_next = tail ? head_value : right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // entry storage, no reset: only slots below the count are ever read
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/svl_seq.sv
// ---------------------------------------------------------------------------
// svl_seq: request sequencer
// Decodes requests, keeps the entry count, steps a dump through the cell
// ring and holds the response register.
// ---------------------------------------------------------------------------
`default_nettype none

module svl_seq #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire svl_pkg::svl_req_t  req_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output svl_pkg::svl_rsp_t       rsp_data,
    input  wire logic               found,
    input  wire logic [31:0]        head_value,
    output svl_pkg::svl_cmd_t       cmd,
    output logic [CNT_W-1:0]        count
);
    import svl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic               rsp_valid_reg, rsp_valid_next;
    svl_rsp_t           rsp_reg, rsp_next;

    logic               out_free;
    logic [CMP_W-1:0]   count_wide;
    logic [CMP_W-1:0]   step_wide;
    logic [CMP_W-1:0]   dump_len;
    logic [CMP_W-1:0]   occ_wide;
    logic               emitting;
    logic               last_emit;
    logic               full;
    logic               empty;
    logic               load;
    svl_status_t        ld_status;
    logic [31:0]        ld_value;
    logic               ld_last;

    // response register is free when empty or being taken
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;

    // dump length and progress
    assign count_wide = CMP_W'(count_reg);
    assign step_wide  = CMP_W'(step_reg);
    assign dump_len   = (count_wide > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : count_wide;
    assign emitting   = step_wide < dump_len;
    assign last_emit  = (step_wide + CMP_W'(1)) == dump_len;
    assign full       = count_reg == CNT_W'(CAPACITY);
    assign empty      = count_reg == '0;

    // request decode and dump stepping
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        cmd        = CMD_HOLD;
        load       = 1'b0;
        ld_status  = ST_OK;
        ld_value   = '0;
        ld_last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    case (req_data.opcode)
                        OP_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                ld_status = ST_FULL;
                            end
                            else
                            begin
                                cmd        = CMD_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            load = 1'b1;
                            if (empty)
                            begin
                                ld_status = ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                ld_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd        = CMD_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            load       = 1'b1;
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // rotate the ring once per step, emitting the head while in range
                if (!emitting || out_free)
                begin
                    cmd       = CMD_ROTATE;
                    step_next = step_reg + CNT_W'(1);
                    if (emitting)
                    begin
                        load     = 1'b1;
                        ld_value = head_value;
                        ld_last  = last_emit;
                    end
                    if (step_reg == count_reg - CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response register load
    assign occ_wide = CMP_W'(count_next);

    always_comb
    begin
        rsp_next = rsp_reg;
        if (load)
        begin
            rsp_next.status      = ld_status;
            rsp_next.entry_value = ld_value;
            rsp_next.last_of_run = ld_last;
            rsp_next.occupancy   = occ_wide[4:0];
        end
        rsp_valid_next = load || (rsp_valid_reg && !rsp_ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_value_list.sv
// Sorted value list: holds up to CAPACITY signed values in ascending order
// in a row of cells. For insert and remove all cells compare against the
// operand at once and shift toward their neighbor in the same cycle, and
// clear resets the count; one such request is accepted per cycle while the
// response register is free. A dump of a list holding N entries occupies
// the block for N steps: the cell ring rotates by one slot per step, the head
// cell supplying the emitted entry, and after N steps the order is back in
// place; the first min(N, 16) entries are emitted, one per cycle unless the
// response side stalls. A dump or remove on an empty list answers ST_EMPTY.
// Occupancy reports the entry count modulo 32; entries wider than 32 bits are
// reported by their low 32 bits.
// ---------------------------------------------------------------------------
// sorted_value_list: bounded sorted multiset
// Top level: the cell row and the request sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_value_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire svl_pkg::svl_req_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output svl_pkg::svl_rsp_t      rsp_data
);
    import svl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    svl_cmd_t               cmd_w;
    logic [CNT_W-1:0]       count_w;
    logic [DATA_WIDTH-1:0]  operand_w;
    logic [DATA_WIDTH-1:0]  val_w  [CAPACITY];
    logic                   lt_w   [CAPACITY];
    logic                   seen_w [CAPACITY+1];
    logic [EXT_W-1:0]       head_ext;
    logic                   found_w;

    // operand at storage width, sign extended or truncated
    assign operand_w = DATA_WIDTH'(req_data.operand);
    assign head_ext  = EXT_W'($signed(val_w[0]));
    assign seen_w[0] = 1'b0;
    assign found_w   = seen_w[CAPACITY];

    // row of list cells
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic                  left_lt;
        logic [DATA_WIDTH-1:0] left_value;
        logic [DATA_WIDTH-1:0] right_value;

        if (gi == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = val_w[0];
        end
        else
        begin : g_mid
            assign left_lt    = lt_w[gi-1];
            assign left_value = val_w[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_value = val_w[gi];
        end
        else
        begin : g_inner
            assign right_value = val_w[gi+1];
        end

        svl_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd_w),
            .operand     (operand_w),
            .used        (CNT_W'(gi) < count_w),
            .tail        (count_w == CNT_W'(gi + 1)),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (val_w[0]),
            .seen_in     (seen_w[gi]),
            .value       (val_w[gi]),
            .lt          (lt_w[gi]),
            .seen_out    (seen_w[gi+1])
        );
    end

    // request sequencer and response register
    svl_seq #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .found      (found_w),
        .head_value (head_ext[31:0]),
        .cmd        (cmd_w),
        .count      (count_w)
    );

`ifndef NO_ASSERTIONS
    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_w <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // no request taken while a response is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> !(rsp_valid && !rsp_ready))
        else $error("request accepted over a stalled response");

    // a successful remove drops the count by one
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_data.opcode == OP_REMOVE
         && count_w != '0 && found_w)
        |=> count_w == $past(count_w) - CNT_W'(1))
        else $error("remove did not shrink the list");

    // a dump of a non-empty list holds off the next request
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_data.opcode == OP_DUMP && count_w != '0)
        |=> !req_ready)
        else $error("request accepted during dump");
`endif

endmodule

`default_nettype wire
